// ===== design/pbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfm_pkg
// shared constants and types of the page buffer frame manager
// ----------------------------------------------------------------------------
package pbfm_pkg;

  localparam int unsigned NUM_FRAMES = 32;
  localparam int unsigned IDX_W     = $clog2(NUM_FRAMES);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned PAGE_W    = 32;
  localparam int unsigned PIN_W     = 16;
  localparam int unsigned FRAME_W   = 5;
  localparam int unsigned CTR_W     = 32;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  localparam logic [2:0] MODE_FETCH     = 3'd0;
  localparam logic [2:0] MODE_UNPIN     = 3'd1;
  localparam logic [2:0] MODE_FLUSH     = 3'd2;
  localparam logic [2:0] MODE_FLUSH_ALL = 3'd3;
  localparam logic [2:0] MODE_NEW       = 3'd4;
  localparam logic [2:0] MODE_DELETE    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_NOFRAME = 2'd2;
  localparam logic [1:0] ST_PIN     = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_index;
    logic               was_hit;
    logic               writeback_valid;
    logic [PAGE_W-1:0]  writeback_page;
    logic               read_valid;
    logic               dealloc_valid;
    logic               last;
  } pbfm_res_t;

endpackage

// ===== design/pbfm_if.sv =====
// ----------------------------------------------------------------------------
// pbfm request and response channels
// valid/ready channels carrying one request or one result
// ----------------------------------------------------------------------------
interface pbfm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] page_id;
  logic        mark_dirty;
  logic [31:0] allocated_page;

  modport source (output valid, mode, page_id, mark_dirty, allocated_page, input ready);
  modport sink   (input valid, mode, page_id, mark_dirty, allocated_page, output ready);
endinterface

interface pbfm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  frame_index;
  logic        was_hit;
  logic        writeback_valid;
  logic [31:0] writeback_page;
  logic        read_valid;
  logic        dealloc_valid;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic        last;

  modport source (output valid, status, frame_index, was_hit, writeback_valid,
                  writeback_page, read_valid, dealloc_valid, hit_total, miss_total,
                  last, input ready);
  modport sink   (input valid, status, frame_index, was_hit, writeback_valid,
                  writeback_page, read_valid, dealloc_valid, hit_total, miss_total,
                  last, output ready);
endinterface

// ===== design/page_buffer_frame_manager.sv =====
// ----------------------------------------------------------------------------
// page_buffer_frame_manager
// buffer pool manager: page lookup, pinning, free stack and lru replacement
// ----------------------------------------------------------------------------
// operation: lookup scans the frame ram, reading and comparing each resident
//   frame in turn, then updates state and walks the lru list; an unknown mode
//   or a flush all with nothing dirty goes straight to the result
// throughput: one request at a time; flush all gives one result per dirty
//   frame, each found by a scan of one frame per cycle
// reset: all frames invalid, free stack full, lru list empty, counters zero
module page_buffer_frame_manager (
  input  logic clk_i,
  input  logic rst_ni,
  pbfm_req_if.sink   req_i,
  pbfm_rsp_if.source rsp_o
);
  import pbfm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_ACT, S_VIC, S_VIC_FS, S_VIC_LRU, S_VIC_PG,
    S_LR_RD, S_LR_CMP, S_SH_RD, S_SH_WR, S_FA_CHK, S_FA_RD, S_EMIT
  } state_e;

  localparam int unsigned FR_W = PAGE_W + PIN_W;

  state_e                state_q;
  logic [IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]      j_q;
  logic [CNT_W-1:0]      len_q;
  logic [CNT_W-1:0]      free_top_q;
  logic [NUM_FRAMES-1:0] valid_q;
  logic [NUM_FRAMES-1:0] dirty_q;
  logic [NUM_FRAMES-1:0] fs_wr_q;
  logic [CTR_W-1:0]      hit_q;
  logic [CTR_W-1:0]      miss_q;
  logic [2:0]            mode_q;
  logic [PAGE_W-1:0]     pid_q;
  logic                  md_q;
  logic [PAGE_W-1:0]     alloc_q;
  logic                  found_q;
  logic [IDX_W-1:0]      f_q;
  logic [PIN_W-1:0]      pin_q;
  pbfm_res_t             res_q;
  pbfm_res_t             out_q;
  logic [CTR_W-1:0]      out_hit_q;
  logic [CTR_W-1:0]      out_miss_q;
  logic                  out_valid_q;

  // frame ram: {page, pin count}
  logic              fr_we;
  logic [IDX_W-1:0]  fr_addr;
  logic [FR_W-1:0]   fr_wdata;
  logic [FR_W-1:0]   fr_rdata;
  // lru order ram
  logic              lru_we;
  logic [IDX_W-1:0]  lru_addr;
  logic [IDX_W-1:0]  lru_wdata;
  logic [IDX_W-1:0]  lru_rdata;
  // free stack ram
  logic              fs_we;
  logic [IDX_W-1:0]  fs_addr;
  logic [IDX_W-1:0]  fs_wdata;
  logic [IDX_W-1:0]  fs_rdata;

  pbfm_ram #(.WIDTH(FR_W), .DEPTH(NUM_FRAMES)) u_frame_ram (
    .clk_i, .we_i(fr_we), .addr_i(fr_addr), .wdata_i(fr_wdata), .rdata_o(fr_rdata)
  );
  pbfm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_FRAMES)) u_lru_ram (
    .clk_i, .we_i(lru_we), .addr_i(lru_addr), .wdata_i(lru_wdata), .rdata_o(lru_rdata)
  );
  pbfm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_FRAMES)) u_free_ram (
    .clk_i, .we_i(fs_we), .addr_i(fs_addr), .wdata_i(fs_wdata), .rdata_o(fs_rdata)
  );

  // helper values
  logic [PAGE_W-1:0]     rd_page;
  logic [PIN_W-1:0]      rd_pin;
  logic [PIN_W-1:0]      pin_inc;
  logic [PIN_W-1:0]      pin_dec;
  logic [NUM_FRAMES-1:0] vd;
  logic [NUM_FRAMES-1:0] vd_above;
  logic [IDX_W-1:0]      fs_victim;
  logic [IDX_W-1:0]      top_idx;
  logic [CNT_W-1:0]      j_next;
  logic                  emit_load;
  logic                  is_new;

  assign rd_page   = fr_rdata[FR_W-1:PIN_W];
  assign rd_pin    = fr_rdata[PIN_W-1:0];
  assign pin_inc   = (pin_q == PIN_MAX) ? pin_q : pin_q + PIN_W'(1);
  assign pin_dec   = pin_q - PIN_W'(1);
  assign vd        = valid_q & dirty_q;
  // dirty frames beyond the current scan position
  assign vd_above  = vd & ((~NUM_FRAMES'(0) << idx_q) << 1);
  assign top_idx   = free_top_q[IDX_W-1:0];
  // unwritten free stack entries hold their own index
  assign fs_victim = fs_wr_q[top_idx] ? fs_rdata : top_idx;
  assign j_next    = j_q + CNT_W'(1);
  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || rsp_o.ready);
  assign is_new    = (mode_q == MODE_NEW);

  // memory port control
  always_comb begin
    fr_we     = 1'b0;
    fr_addr   = idx_q;
    fr_wdata  = {pid_q, pin_inc};
    lru_we    = 1'b0;
    lru_addr  = j_q[IDX_W-1:0];
    lru_wdata = f_q;
    fs_we     = 1'b0;
    fs_addr   = top_idx;
    fs_wdata  = f_q;
    unique case (state_q)
      S_ACT: begin
        fr_addr = f_q;
        if (found_q) begin
          if (mode_q == MODE_FETCH) begin
            fr_we = 1'b1;
          end else if (mode_q == MODE_UNPIN && pin_q != '0) begin
            fr_we    = 1'b1;
            fr_wdata = {pid_q, pin_dec};
            if (pin_dec == '0) begin
              lru_we   = 1'b1;
              lru_addr = len_q[IDX_W-1:0];
            end
          end else if (mode_q == MODE_DELETE && pin_q == '0 &&
                       free_top_q < CNT_W'(NUM_FRAMES)) begin
            fs_we = 1'b1;
          end
        end
      end
      S_VIC: begin
        fs_addr  = top_idx - IDX_W'(1);
        lru_addr = '0;
      end
      S_VIC_FS:  fr_addr = fs_victim;
      S_VIC_LRU: fr_addr = lru_rdata;
      S_VIC_PG: begin
        fr_we    = 1'b1;
        fr_addr  = f_q;
        fr_wdata = {(is_new ? alloc_q : pid_q), PIN_W'(1)};
      end
      S_SH_RD: lru_addr = j_next[IDX_W-1:0];
      S_SH_WR: begin
        lru_we    = 1'b1;
        lru_wdata = lru_rdata;
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      j_q         <= '0;
      len_q       <= '0;
      free_top_q  <= CNT_W'(NUM_FRAMES);
      valid_q     <= '0;
      dirty_q     <= '0;
      fs_wr_q     <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rsp_o.ready && !emit_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            mode_q  <= req_i.mode;
            pid_q   <= req_i.page_id;
            md_q    <= req_i.mark_dirty;
            alloc_q <= req_i.allocated_page;
            idx_q   <= '0;
            found_q <= 1'b0;
            // flush all with dirty frames ends on the last one found
            res_q   <= '{status: ST_OK,
                         last: !(req_i.mode == MODE_FLUSH_ALL && vd != '0),
                         default: '0};
            priority case (req_i.mode)
              MODE_FETCH, MODE_UNPIN, MODE_FLUSH, MODE_DELETE: state_q <= S_LK_RD;
              MODE_NEW:  state_q <= S_VIC;
              MODE_FLUSH_ALL: begin
                if (vd == '0) begin
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_FA_CHK;
                end
              end
              default: state_q <= S_EMIT;
            endcase
          end
        end
        S_LK_RD: begin
          if (valid_q[idx_q]) begin
            state_q <= S_LK_CMP;
          end else if (idx_q == IDX_W'(NUM_FRAMES - 1)) begin
            state_q <= S_ACT;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_LK_CMP: begin
          if (rd_page == pid_q) begin
            found_q <= 1'b1;
            f_q     <= idx_q;
            pin_q   <= rd_pin;
            state_q <= S_ACT;
          end else if (idx_q == IDX_W'(NUM_FRAMES - 1)) begin
            state_q <= S_ACT;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_LK_RD;
          end
        end
        S_ACT: begin
          j_q <= '0;
          priority case (mode_q)
            MODE_FETCH: begin
              if (found_q) begin
                hit_q             <= hit_q + CTR_W'(1);
                res_q.was_hit     <= 1'b1;
                res_q.frame_index <= FRAME_W'(f_q);
                state_q           <= S_LR_RD;
              end else begin
                miss_q  <= miss_q + CTR_W'(1);
                state_q <= S_VIC;
              end
            end
            MODE_UNPIN: begin
              state_q <= S_EMIT;
              if (!found_q) begin
                res_q.status <= ST_ABSENT;
              end else if (pin_q == '0) begin
                res_q.status <= ST_PIN;
              end else begin
                res_q.frame_index <= FRAME_W'(f_q);
                if (md_q) dirty_q[f_q] <= 1'b1;
                if (pin_dec == '0) len_q <= len_q + CNT_W'(1);
              end
            end
            MODE_FLUSH: begin
              state_q <= S_EMIT;
              if (!found_q) begin
                res_q.status <= ST_ABSENT;
              end else begin
                dirty_q[f_q]          <= 1'b0;
                res_q.frame_index     <= FRAME_W'(f_q);
                res_q.writeback_valid <= 1'b1;
                res_q.writeback_page  <= pid_q;
              end
            end
            default: begin
              // delete
              if (!found_q) begin
                res_q.dealloc_valid <= 1'b1;
                state_q             <= S_EMIT;
              end else if (pin_q != '0) begin
                res_q.status <= ST_PIN;
                state_q      <= S_EMIT;
              end else begin
                valid_q[f_q]        <= 1'b0;
                dirty_q[f_q]        <= 1'b0;
                res_q.frame_index   <= FRAME_W'(f_q);
                res_q.dealloc_valid <= 1'b1;
                if (free_top_q < CNT_W'(NUM_FRAMES)) begin
                  fs_wr_q[top_idx] <= 1'b1;
                  free_top_q       <= free_top_q + CNT_W'(1);
                end
                state_q <= S_LR_RD;
              end
            end
          endcase
        end
        S_VIC: begin
          if (free_top_q != '0) begin
            free_top_q <= free_top_q - CNT_W'(1);
            state_q    <= S_VIC_FS;
          end else if (len_q != '0) begin
            state_q <= S_VIC_LRU;
          end else begin
            res_q.status <= ST_NOFRAME;
            state_q      <= S_EMIT;
          end
        end
        S_VIC_FS: begin
          f_q     <= fs_victim;
          state_q <= S_VIC_PG;
        end
        S_VIC_LRU: begin
          f_q     <= lru_rdata;
          state_q <= S_VIC_PG;
        end
        S_VIC_PG: begin
          if (vd[f_q]) begin
            res_q.writeback_valid <= 1'b1;
            res_q.writeback_page  <= rd_page;
          end
          valid_q[f_q]      <= 1'b1;
          dirty_q[f_q]      <= is_new;
          res_q.frame_index <= FRAME_W'(f_q);
          res_q.read_valid  <= !is_new;
          j_q               <= '0;
          state_q           <= S_LR_RD;
        end
        // lru removal: find the frame, then shift the tail down by one
        S_LR_RD: state_q <= (j_q == len_q) ? S_EMIT : S_LR_CMP;
        S_LR_CMP: begin
          if (lru_rdata == f_q) begin
            state_q <= S_SH_RD;
          end else begin
            j_q     <= j_next;
            state_q <= S_LR_RD;
          end
        end
        S_SH_RD: begin
          if (j_next == len_q) begin
            len_q   <= len_q - CNT_W'(1);
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          j_q     <= j_next;
          state_q <= S_SH_RD;
        end
        S_FA_CHK: begin
          if (vd[idx_q]) begin
            state_q <= S_FA_RD;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_FA_RD: begin
          dirty_q[idx_q]        <= 1'b0;
          res_q.frame_index     <= FRAME_W'(idx_q);
          res_q.writeback_valid <= 1'b1;
          res_q.writeback_page  <= rd_page;
          res_q.last            <= (vd_above == '0);
          state_q               <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            out_hit_q   <= hit_q;
            out_miss_q  <= miss_q;
            if (res_q.last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_FA_CHK;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.frame_index     = out_q.frame_index;
  assign rsp_o.was_hit         = out_q.was_hit;
  assign rsp_o.writeback_valid = out_q.writeback_valid;
  assign rsp_o.writeback_page  = out_q.writeback_page;
  assign rsp_o.read_valid      = out_q.read_valid;
  assign rsp_o.dealloc_valid   = out_q.dealloc_valid;
  assign rsp_o.hit_total       = out_hit_q;
  assign rsp_o.miss_total      = out_miss_q;
  assign rsp_o.last            = out_q.last;

  a_free_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= CNT_W'(NUM_FRAMES)) else $error("free stack pointer overrun");
  a_lru_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(NUM_FRAMES)) else $error("lru list overrun");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && out_valid_q) |-> rsp_o.ready) else $error("pending result lost");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VIC_FS) |-> ($past(free_top_q) != '0))
    else $error("pop from empty free stack");

endmodule

// ===== design/pbfm_ram.sv =====
// ----------------------------------------------------------------------------
// pbfm_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module pbfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
